FILE: design/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/spq_pkg.sv
//------------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted-array priority queue
//------------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int VAL_W = 32;
    localparam int PRI_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_ENQUEUE  = 2'd0,
        OP_DEQUEUE  = 2'd1,
        OP_READ_ALL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic             do_enq;
        logic             do_deq;
        logic             load_out;
        logic             use_entry;
        status_t          status;
        logic             last;
        logic [IDX_W-1:0] rd_idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
    } stat_t;

endpackage

FILE: design/sorted_array_priority_queue_unit.sv
//------------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// priority queue of value/priority pairs kept as a sorted register array
//------------------------------------------------------------------------------
// The queue holds up to spq_pkg::DEPTH entries in ascending priority from the
// head, one compare-and-shift cell per entry. On an enqueue request every cell
// compares its priority with the new one in parallel and either holds, takes
// the new pair or takes its lower neighbor, so among equal priorities the
// newest entry comes out first. A dequeue request shifts the entries toward the
// head. Both give a single result in the cycle after acceptance, and the input
// is taken again in the cycle the result leaves or earlier, so enqueues and
// dequeues sustain one request per cycle while out_ready is high. A read-all
// request streams one entry per cycle while out_ready is high, from head to
// tail through the output register with last set on the tail, and holds off
// new requests until the tail is taken. Results with a full or empty status
// carry a zero value. Opcode 3 is dropped without a result. The user must write
// the capacity register through cfg_write_en and cfg_write_data only while
// the queue is idle; the block does not enforce this. Values above the depth
// saturate. No clearing pass runs after reset: the entry count starts at zero.
//------------------------------------------------------------------------------
module sorted_array_priority_queue_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_write_en,
    input  logic [spq_pkg::CAP_W-1:0]        cfg_write_data,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic signed [spq_pkg::VAL_W-1:0] item_value,
    input  logic signed [spq_pkg::PRI_W-1:0] item_priority,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [spq_pkg::VAL_W-1:0] value_out,
    output logic [1:0]                       status,
    output logic                             last
);

    // command from the sequencer, count and full/empty flags back
    spq_pkg::cmd_t  cmd;
    spq_pkg::stat_t stat;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // entry cells, capacity register and result payload register
    spq_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_value     (item_value),
        .item_priority  (item_priority),
        .cmd            (cmd),
        .stat           (stat),
        .value_out      (value_out),
        .status         (status),
        .last           (last)
    );

endmodule

FILE: design/spq_ctrl.sv
//------------------------------------------------------------------------------
// spq_ctrl
// request sequencing, read-out streaming and output valid control
//------------------------------------------------------------------------------
module spq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     operation,
    output logic           out_valid,
    input  logic           out_ready,
    input  spq_pkg::stat_t stat,
    output spq_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_STREAM = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [spq_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_free;
    logic                      accept;
    logic                      stream_last;

    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE) && out_free;
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign stream_last = (spq_pkg::CNT_W'(idx_reg) + spq_pkg::CNT_W'(1)) == stat.count;

    always_comb
    begin
        cmd        = '0;
        cmd.status = spq_pkg::ST_OK;
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        spq_pkg::OP_ENQUEUE:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.last     = 1'b1;
                            if (stat.full)
                                cmd.status = spq_pkg::ST_FULL;
                            else
                                cmd.do_enq = 1'b1;
                        end
                        spq_pkg::OP_DEQUEUE:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.last     = 1'b1;
                            if (stat.empty)
                                cmd.status = spq_pkg::ST_EMPTY;
                            else
                            begin
                                cmd.do_deq    = 1'b1;
                                cmd.use_entry = 1'b1;
                            end
                        end
                        spq_pkg::OP_READ_ALL:
                        begin
                            cmd.load_out = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.status = spq_pkg::ST_EMPTY;
                                cmd.last   = 1'b1;
                            end
                            else
                            begin
                                cmd.use_entry = 1'b1;
                                cmd.last      = (stat.count == spq_pkg::CNT_W'(1));
                                if (!cmd.last)
                                begin
                                    state_next = S_STREAM;
                                    idx_next   = spq_pkg::IDX_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // unused code: no result, state unchanged
                        end
                    endcase
                end
            end
            S_STREAM:
            begin
                if (out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.use_entry = 1'b1;
                    cmd.rd_idx    = idx_reg;
                    cmd.last      = stream_last;
                    idx_next      = idx_reg + spq_pkg::IDX_W'(1);
                    if (stream_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/spq_datapath.sv
//------------------------------------------------------------------------------
// spq_datapath
// compare-and-shift entry cells, entry count, capacity and output register
//------------------------------------------------------------------------------
module spq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [spq_pkg::CAP_W-1:0]           cfg_write_data,
    input  logic signed [spq_pkg::VAL_W-1:0]    item_value,
    input  logic signed [spq_pkg::PRI_W-1:0]    item_priority,
    input  spq_pkg::cmd_t                       cmd,
    output spq_pkg::stat_t                      stat,
    output logic signed [spq_pkg::VAL_W-1:0]    value_out,
    output logic [1:0]                          status,
    output logic                                last
);

    logic signed [spq_pkg::VAL_W-1:0] val_reg  [spq_pkg::DEPTH];
    logic signed [spq_pkg::VAL_W-1:0] val_next [spq_pkg::DEPTH];
    logic signed [spq_pkg::PRI_W-1:0] pri_reg  [spq_pkg::DEPTH];
    logic signed [spq_pkg::PRI_W-1:0] pri_next [spq_pkg::DEPTH];
    logic [spq_pkg::DEPTH-1:0]        lt;

    logic [spq_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [spq_pkg::CAP_W-1:0]        cap_reg;
    logic [spq_pkg::CMP_W-1:0]        cap_sat;
    logic [spq_pkg::CMP_W-1:0]        count_ext;

    logic signed [spq_pkg::VAL_W-1:0] value_out_reg;
    logic [1:0]                       status_reg;
    logic                             last_reg;

    // capacity above the array depth saturates
    assign count_ext = spq_pkg::CMP_W'(count_reg);
    assign cap_sat   = (spq_pkg::CMP_W'(cap_reg) > spq_pkg::CMP_W'(spq_pkg::DEPTH))
                     ? spq_pkg::CMP_W'(spq_pkg::DEPTH) : spq_pkg::CMP_W'(cap_reg);

    assign stat.full  = count_ext >= cap_sat;
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    // per-cell compare: entry in use and strictly lower priority
    always_comb
    begin
        for (int i = 0; i < spq_pkg::DEPTH; i++)
            lt[i] = (spq_pkg::CNT_W'(i) < count_reg) && (pri_reg[i] < item_priority);
    end

    for (genvar i = 0; i < spq_pkg::DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
            if (cmd.do_enq)
            begin
                if (lt[i])
                begin
                    val_next[i] = val_reg[i];
                    pri_next[i] = pri_reg[i];
                end
                else if ((i == 0) || lt[(i == 0) ? 0 : i - 1])
                begin
                    val_next[i] = item_value;
                    pri_next[i] = item_priority;
                end
                else
                begin
                    val_next[i] = val_reg[(i == 0) ? 0 : i - 1];
                    pri_next[i] = pri_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (cmd.do_deq && (i < spq_pkg::DEPTH - 1))
            begin
                val_next[i] = val_reg[(i < spq_pkg::DEPTH - 1) ? i + 1 : i];
                pri_next[i] = pri_reg[(i < spq_pkg::DEPTH - 1) ? i + 1 : i];
            end
        end

        always_ff @(posedge clk)
        begin
            val_reg[i] <= val_next[i];
            pri_reg[i] <= pri_next[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_enq)
            count_next = count_reg + spq_pkg::CNT_W'(1);
        else if (cmd.do_deq)
            count_next = count_reg - spq_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= spq_pkg::CAP_RESET;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_write_en)
                cap_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            value_out_reg <= cmd.use_entry ? val_reg[cmd.rd_idx] : '0;
            status_reg    <= cmd.status;
            last_reg      <= cmd.last;
        end
    end

    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

FILE: design/spq_checker.sv
//------------------------------------------------------------------------------
// spq_checker
// port-level checks of the priority queue, bound to the top level
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module spq_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic signed [spq_pkg::VAL_W-1:0] value_out,
    input  logic [1:0]                       status,
    input  logic                             last
);

    logic enq_deq_accept;

    assign enq_deq_accept = in_valid && in_ready &&
                            (operation == spq_pkg::OP_ENQUEUE ||
                             operation == spq_pkg::OP_DEQUEUE);

    // single-result requests show their result in the next cycle
    `ASSERT_NEXT(a_single_result, clk, rst_n, enq_deq_accept, out_valid && last)

    // a read-out in progress holds off new requests
    `ASSERT_IMPL(a_stream_blocks, clk, rst_n, out_valid && !last, !in_ready)

    // full and empty results carry a zero value and end the request
    `ASSERT_IMPL(a_error_zero, clk, rst_n, out_valid && (status != spq_pkg::ST_OK),
                 (value_out == '0) && last)

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                 out_valid && $stable(value_out) && $stable(status) && $stable(last))

endmodule

bind sorted_array_priority_queue_unit spq_checker u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_out (value_out),
    .status    (status),
    .last      (last)
);
